// ===== src/fsa_pkg.sv =====
// Shared types and codes for the fixed slot allocator.
// No dependencies; used by fixed_slot_allocator.sv.

package fsa_pkg;

    localparam int SlotW   = 10;
    localparam int StatusW = 3;
    localparam int CountW  = 11;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef enum logic [StatusW-1:0] {
        ST_GRANTED        = 3'd0,
        ST_EXHAUSTED      = 3'd1,
        ST_FREED_TAIL     = 3'd2,
        ST_FREED_OVERFLOW = 3'd3,
        ST_REJECTED       = 3'd4
    } t_status;

    // Where the slot index of a pending result comes from.
    typedef enum logic [1:0] {
        SRC_REG  = 2'd0,
        SRC_TAIL = 2'd1,
        SRC_OVF  = 2'd2
    } t_src;

endpackage

// ===== src/fixed_slot_allocator.sv =====
// Fixed slot allocator: top level with the tail and overflow stack memories.
// Depends on fsa_pkg for status codes and field widths.
//
// Usage:
//   Request channel i_valid/o_ready carries i_operation (0 allocate, 1 free)
//   and i_slot_in (slot to free). Result channel o_valid/i_ready returns
//   o_slot_out and o_status, one result per request, in request order.
//   Configuration channel i_cfg_valid/o_cfg_ready writes the slot count;
//   values below four select 1024 slots, and the count is capped at MAX_SLOTS.
//   Each request updates the stack counters on acceptance and, for a pop,
//   reads one stack memory into a read data register, loaded together with
//   the pending result stage, which then loads the output register that
//   drives o_valid. Throughput: one request per cycle while the receiver
//   takes results, set by the single port of each stack memory; a push and
//   a pop of the same entry fall in different cycles, so a pop needs no
//   forwarding. When the receiver stalls, the output register and the
//   pending stage hold one result each; further requests wait in the
//   sender until they drain. Reset clears the counters and empties both
//   stacks; the memories hold no reset value and need no clearing pass.

module fixed_slot_allocator #(
    parameter int MAX_SLOTS      = 1024,
    parameter int ELT_BYTES      = 8,
    parameter int REC_BYTES      = 8,
    parameter int OVERFLOW_DEPTH = 1024
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic                          i_operation,
    input  logic [fsa_pkg::SlotW-1:0]     i_slot_in,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [fsa_pkg::SlotW-1:0]     o_slot_out,
    output logic [fsa_pkg::StatusW-1:0]   o_status,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [fsa_pkg::CountW-1:0]    i_cfg_slot_count
);

    localparam int TailDepth = (MAX_SLOTS * ELT_BYTES + REC_BYTES - 1) / REC_BYTES;
    localparam int NW  = $clog2(MAX_SLOTS + 1);
    localparam int CW  = (NW > fsa_pkg::CountW) ? NW : fsa_pkg::CountW;
    localparam int TW  = $clog2(TailDepth + 1);
    localparam int OW  = $clog2(OVERFLOW_DEPTH + 1);
    localparam int TAW = (TailDepth > 1) ? $clog2(TailDepth) : 1;
    localparam int OAW = (OVERFLOW_DEPTH > 1) ? $clog2(OVERFLOW_DEPTH) : 1;
    localparam int BW  = $clog2(MAX_SLOTS * ELT_BYTES + (TailDepth + 1) * REC_BYTES + 1) + 1;

    localparam logic [CW-1:0] DefaultCount = CW'(1024);
    localparam logic [CW-1:0] MinCount     = CW'(4);
    localparam logic [CW-1:0] MaxCount     = CW'(MAX_SLOTS);
    localparam logic [TW-1:0] TailFull     = TW'(TailDepth);
    localparam logic [OW-1:0] OvfFull      = OW'(OVERFLOW_DEPTH);
    localparam logic [BW-1:0] EltB         = BW'(ELT_BYTES);
    localparam logic [BW-1:0] RecB         = BW'(REC_BYTES);

    logic [fsa_pkg::CountW-1:0] r_slot_count;
    logic [NW-1:0]              r_fresh_next, n_fresh_next;
    logic [TW-1:0]              r_tail_count, n_tail_count;
    logic [OW-1:0]              r_ovf_count,  n_ovf_count;

    logic [fsa_pkg::SlotW-1:0]  tail_mem [TailDepth];
    logic [fsa_pkg::SlotW-1:0]  ovf_mem  [OVERFLOW_DEPTH];
    logic [fsa_pkg::SlotW-1:0]  r_tail_rdata;
    logic [fsa_pkg::SlotW-1:0]  r_ovf_rdata;

    // Pending result stage.
    logic                       r_res_valid;
    fsa_pkg::t_status           r_res_status, n_res_status;
    fsa_pkg::t_src              r_res_src,    n_res_src;
    logic [fsa_pkg::SlotW-1:0]  r_res_slot,   n_res_slot;

    // Output register.
    logic                       r_out_valid;
    logic [fsa_pkg::SlotW-1:0]  r_out_slot;
    fsa_pkg::t_status           r_out_status;

    logic                       accept;
    logic                       move;
    logic [CW-1:0]              cnt_ext;
    logic [CW-1:0]              n_eff;
    logic [BW-1:0]              used_bytes;
    logic [BW-1:0]              pool_bytes;
    logic                       tail_room;
    logic                       tail_push, tail_pop, ovf_push, ovf_pop;
    logic [fsa_pkg::SlotW-1:0]  res_slot_sel;

    assign move    = r_res_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_res_valid || move;
    assign accept  = i_valid && o_ready;
    assign o_cfg_ready = 1'b1;

    always_comb begin
        cnt_ext = CW'(r_slot_count);
        n_eff   = (cnt_ext < MinCount) ? DefaultCount : cnt_ext;
        if (n_eff > MaxCount) begin
            n_eff = MaxCount;
        end
    end

    // The room test fresh*E < n*E - (tail+1)*R, folded into one add and compare.
    assign used_bytes = BW'(r_fresh_next) * EltB + (BW'(r_tail_count) + BW'(1)) * RecB;
    assign pool_bytes = BW'(n_eff) * EltB;
    assign tail_room  = (used_bytes < pool_bytes) && (r_tail_count < TailFull);

    always_comb begin
        n_fresh_next = r_fresh_next;
        n_tail_count = r_tail_count;
        n_ovf_count  = r_ovf_count;
        n_res_status = fsa_pkg::ST_REJECTED;
        n_res_src    = fsa_pkg::SRC_REG;
        n_res_slot   = '0;
        tail_push    = 1'b0;
        tail_pop     = 1'b0;
        ovf_push     = 1'b0;
        ovf_pop      = 1'b0;
        if (i_operation == fsa_pkg::OP_ALLOC) begin
            priority if (r_tail_count != '0) begin
                tail_pop     = 1'b1;
                n_tail_count = r_tail_count - TW'(1);
                n_res_status = fsa_pkg::ST_GRANTED;
                n_res_src    = fsa_pkg::SRC_TAIL;
            end else if (r_ovf_count != '0) begin
                ovf_pop      = 1'b1;
                n_ovf_count  = r_ovf_count - OW'(1);
                n_res_status = fsa_pkg::ST_GRANTED;
                n_res_src    = fsa_pkg::SRC_OVF;
            end else if (CW'(r_fresh_next) < n_eff) begin
                n_fresh_next = r_fresh_next + NW'(1);
                n_res_status = fsa_pkg::ST_GRANTED;
                n_res_slot   = r_fresh_next[fsa_pkg::SlotW-1:0];
            end else begin
                n_res_status = fsa_pkg::ST_EXHAUSTED;
            end
        end else begin
            priority if (CW'(i_slot_in) >= n_eff) begin
                n_res_status = fsa_pkg::ST_REJECTED;
            end else if (tail_room) begin
                tail_push    = 1'b1;
                n_tail_count = r_tail_count + TW'(1);
                n_res_status = fsa_pkg::ST_FREED_TAIL;
            end else if (r_ovf_count < OvfFull) begin
                ovf_push     = 1'b1;
                n_ovf_count  = r_ovf_count + OW'(1);
                n_res_status = fsa_pkg::ST_FREED_OVERFLOW;
            end else begin
                n_res_status = fsa_pkg::ST_REJECTED;
            end
        end
    end

    // Stack memories: at most one access per accepted request.
    always_ff @(posedge i_clk) begin
        if (accept && tail_push) begin
            tail_mem[r_tail_count[TAW-1:0]] <= i_slot_in;
        end
        if (accept && tail_pop) begin
            r_tail_rdata <= tail_mem[n_tail_count[TAW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && ovf_push) begin
            ovf_mem[r_ovf_count[OAW-1:0]] <= i_slot_in;
        end
        if (accept && ovf_pop) begin
            r_ovf_rdata <= ovf_mem[n_ovf_count[OAW-1:0]];
        end
    end

    always_comb begin
        unique case (r_res_src)
            fsa_pkg::SRC_TAIL: res_slot_sel = r_tail_rdata;
            fsa_pkg::SRC_OVF:  res_slot_sel = r_ovf_rdata;
            default:           res_slot_sel = r_res_slot;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_count <= fsa_pkg::CountW'(1024);
            r_fresh_next <= '0;
            r_tail_count <= '0;
            r_ovf_count  <= '0;
            r_res_valid  <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_slot_count <= i_cfg_slot_count;
            end
            if (accept) begin
                r_fresh_next <= n_fresh_next;
                r_tail_count <= n_tail_count;
                r_ovf_count  <= n_ovf_count;
                r_res_valid  <= 1'b1;
            end else if (move) begin
                r_res_valid  <= 1'b0;
            end
            if (move) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_res_status <= n_res_status;
            r_res_src    <= n_res_src;
            r_res_slot   <= n_res_slot;
        end
        if (move) begin
            r_out_slot   <= res_slot_sel;
            r_out_status <= r_res_status;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_slot_out = r_out_slot;
    assign o_status   = r_out_status;

    // A tail pop lowers the tail count by exactly one.
    a_tail_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && tail_pop |=> r_tail_count == $past(r_tail_count) - TW'(1))
        else $error("tail count did not drop on pop");

    // The counters never pass their stack depths.
    a_depths: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tail_count <= TailFull && r_ovf_count <= OvfFull)
        else $error("stack count beyond depth");

    // At most one stack is touched per request.
    a_one_stack: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> $countones({tail_push, tail_pop, ovf_push, ovf_pop}) <= 1)
        else $error("more than one stack access in a request");

    // A result that is not a grant carries a zero slot.
    a_zero_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_status != fsa_pkg::ST_GRANTED |-> r_out_slot == '0)
        else $error("non-grant result with non-zero slot");

    // A pending result that cannot move stays pending with its source unchanged.
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_res_valid && !move |=> r_res_valid && $stable(r_res_src))
        else $error("pending result lost while stalled");

endmodule
